/* hdl/tes_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tes_pkg
// Types, codes and constants shared by the timed event slot table and its
// arithmetic unit.
// ---------------------------------------------------------------------------
package tes_pkg;

  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int SLOT_IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W      = 32;
  localparam int HANDLE_W    = 16;
  localparam int SCALE_W     = 20;

  localparam logic [SCALE_W-1:0] SCALE_SEC = SCALE_W'(1000000);
  localparam logic [SCALE_W-1:0] SCALE_MS  = SCALE_W'(1000);
  localparam logic [SCALE_W-1:0] SCALE_US  = SCALE_W'(1);

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_POLL = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    UNIT_SEC = 2'd0,
    UNIT_MS  = 2'd1,
    UNIT_US  = 2'd2
  } time_unit_t;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_LE  = 2'd2
  } unit_op_t;

  typedef struct packed {
    logic [0:0]          command;
    logic [TIME_W-1:0]   current_time;
    logic [TIME_W-1:0]   time_arg;
    logic [1:0]          unit;
    logic [HANDLE_W-1:0] handle;
  } request_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [2:0]          slot;
    logic [HANDLE_W-1:0] fired_handle;
    logic [0:0]          last;
  } result_t;

  typedef struct packed {
    unit_op_t          op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] y;
    logic              le;
  } unit_rsp_t;

  // Microseconds per delay unit; the unused code behaves as microseconds.
  function automatic logic [SCALE_W-1:0] scale_of(input logic [1:0] u);
    logic [SCALE_W-1:0] s;
    case (u)
      UNIT_SEC: s = SCALE_SEC;
      UNIT_MS:  s = SCALE_MS;
      default:  s = SCALE_US;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* hdl/tes_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tes_unit
// Shared arithmetic unit: delay scaling multiply, deadline add and the
// unsigned at-or-below compare used by the poll scan.
// ---------------------------------------------------------------------------
module tes_unit
  import tes_pkg::*;
(
  input  var unit_req_t req,
  output var unit_rsp_t rsp
);

  logic [TIME_W+SCALE_W-1:0] prod;

  // The scale never needs more than SCALE_W bits, so the multiplier stays narrow.
  assign prod = req.a * req.b[SCALE_W-1:0];

  always_comb begin
    rsp.le = (req.a <= req.b);
    case (req.op)
      OP_MUL:  rsp.y = prod[TIME_W-1:0];
      OP_ADD:  rsp.y = req.a + req.b;
      default: rsp.y = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/timed_event_slot_table.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// timed_event_slot_table
// Fixed table of timed events: add items claim the lowest free slot, poll
// items fire and free every due slot in slot order.
// ---------------------------------------------------------------------------
// Add item: busy for the scale and add steps, then one slot per cycle
// until a free one is found; its result appears in the cycle after.
// Poll item: busy for the scan and a flush step, one slot compare per cycle through the
// shared unit; fired results leave one per cycle at most, the last after the scan.
// Results are strobed for one cycle each and cannot be held off.
// Synchronous reset empties the table and returns the sequencer to idle.
module timed_event_slot_table
  import tes_pkg::*;
(
  input  var logic     clk,
  input  var logic     rst,
  input  var logic     start,
  input  var request_t request,
  output var logic     busy,
  output var logic     result_strobe,
  output var result_t  result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_FIND,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t                  state;
  logic [SLOTS-1:0]        active;
  logic [TIME_W-1:0]       deadline [SLOTS];
  logic [HANDLE_W-1:0]     handles  [SLOTS];
  logic [SLOT_IDX_W-1:0]   idx;
  logic [TIME_W-1:0]       acc;
  logic [TIME_W-1:0]       opnd;
  logic [1:0]              unit_sel;
  logic [HANDLE_W-1:0]     handle_r;
  logic [CNT_W-1:0]        fired_cnt;
  logic                    pend_valid;
  logic [SLOT_IDX_W-1:0]   pend_slot;
  logic [HANDLE_W-1:0]     pend_handle;
  unit_req_t               ureq;
  unit_rsp_t               ursp;
  logic                    at_end;
  logic                    due;

  tes_unit u_unit (
    .req (ureq),
    .rsp (ursp)
  );

  always_comb begin
    ureq.op = OP_LE;
    ureq.a  = deadline[idx];
    ureq.b  = opnd;
    case (state)
      ST_MUL: begin
        ureq.op = OP_MUL;
        ureq.a  = acc;
        ureq.b  = TIME_W'(scale_of(unit_sel));
      end
      ST_ADD: begin
        ureq.op = OP_ADD;
        ureq.a  = acc;
        ureq.b  = opnd;
      end
      default: begin
        ureq.op = OP_LE;
      end
    endcase
  end

  assign busy   = (state != ST_IDLE);
  assign at_end = (idx == SLOT_IDX_W'(SLOTS - 1));
  assign due    = active[idx] && ursp.le && (fired_cnt < CNT_W'(MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active        <= '0;
      result_strobe <= 1'b0;
      pend_valid    <= 1'b0;
      fired_cnt     <= '0;
      idx           <= '0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            idx        <= '0;
            fired_cnt  <= '0;
            pend_valid <= 1'b0;
            handle_r   <= request.handle;
            unit_sel   <= request.unit;
            acc        <= request.time_arg;
            if (request.command == CMD_ADD) begin
              opnd  <= request.current_time;
              state <= ST_MUL;
            end else begin
              opnd  <= (request.time_arg == '0) ? request.current_time
                                                : request.time_arg;
              state <= ST_SCAN;
            end
          end
        end
        ST_MUL: begin
          acc   <= ursp.y;
          state <= ST_ADD;
        end
        ST_ADD: begin
          acc   <= ursp.y;
          state <= ST_FIND;
        end
        ST_FIND: begin
          if (!active[idx]) begin
            active[idx]   <= 1'b1;
            deadline[idx] <= acc;
            handles[idx]  <= handle_r;
            result_strobe <= 1'b1;
            result        <= '{kind: KIND_ADDED, slot: 3'(idx), fired_handle: '0,
                               last: 1'b1};
            state         <= ST_IDLE;
          end else if (at_end) begin
            result_strobe <= 1'b1;
            result        <= '{kind: KIND_FULL, slot: '0, fired_handle: '0,
                               last: 1'b1};
            state         <= ST_IDLE;
          end else begin
            idx <= idx + SLOT_IDX_W'(1);
          end
        end
        ST_SCAN: begin
          // A fired item is held back one step so that the final one can
          // carry last once the scan has ended.
          if (due) begin
            if (pend_valid) begin
              result_strobe <= 1'b1;
              result        <= '{kind: KIND_FIRED, slot: 3'(pend_slot),
                                 fired_handle: pend_handle, last: 1'b0};
            end
            pend_valid  <= 1'b1;
            pend_slot   <= idx;
            pend_handle <= handles[idx];
            active[idx] <= 1'b0;
            fired_cnt   <= fired_cnt + CNT_W'(1);
          end
          if (at_end) begin
            state <= ST_FLUSH;
          end else begin
            idx <= idx + SLOT_IDX_W'(1);
          end
        end
        ST_FLUSH: begin
          result_strobe <= 1'b1;
          if (pend_valid) begin
            result <= '{kind: KIND_FIRED, slot: 3'(pend_slot),
                        fired_handle: pend_handle, last: 1'b1};
          end else begin
            result <= '{kind: KIND_NONE, slot: '0, fired_handle: '0, last: 1'b1};
          end
          pend_valid <= 1'b0;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted item always makes the sequencer busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // Only fired items can be followed by further items of the same poll.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (result.kind == KIND_ADDED || result.kind == KIND_FULL ||
                       result.kind == KIND_NONE)) |-> result.last)
    else $error("non-fired result without last");

  // After the final result of an item nothing follows in the next cycle.
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last) |=> !result_strobe)
    else $error("result strobed straight after a last result");

endmodule
`default_nettype wire
